[sv/cpot_pkg.sv]
// Shared types and constants of the convex polygon overlap test.
package cpot_pkg;

    // Shape codes carried by which_shape and by the internal shape selects.
    localparam logic SHAPE_A = 1'b0;
    localparam logic SHAPE_B = 1'b1;

    // A polygon needs at least this many vertices to have an edge.
    localparam int MIN_POINTS = 2;

    // Sequencer states, one-hot.
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_CHECK = 11'b000_0000_0010,
        ST_E0    = 11'b000_0000_0100,
        ST_E1    = 11'b000_0000_1000,
        ST_E2    = 11'b000_0001_0000,
        ST_PADDR = 11'b000_0010_0000,
        ST_PMULX = 11'b000_0100_0000,
        ST_PMULY = 11'b000_1000_0000,
        ST_PACC  = 11'b001_0000_0000,
        ST_PCMP  = 11'b010_0000_0000,
        ST_TEST  = 11'b100_0000_0000
    } state_t;

endpackage

[sv/convex_polygon_overlap_test.sv]
// Top level of the convex polygon overlap test (separating axis theorem in 2-D).
//
// Usage: each input beat loads one vertex (vertex_x, vertex_y in signed Q12.4)
// into polygon A (which_shape = 0) or polygon B (which_shape = 1). A beat is
// taken at a rising edge where start is high and busy is low. A beat without
// last_of_pair is stored while busy stays low, so vertices can be
// sent back to back. The beat with last_of_pair set is stored first and then
// starts the test; busy stays high until the result beat.
// The result beat (colliding, degenerate, overflowed) is shown for exactly one
// cycle with done high; the receiver cannot stall it, and busy falls in that
// same cycle so the next vertex may already be sent.
// A degenerate pair ends without any axis being tried. For each tried axis
// the edge is fetched, every vertex of both polygons is projected onto it,
// and the two intervals are tested; the single shared multiplier and the one
// read port of each vertex memory take the vertices one at a time. Testing
// stops at the first gap.
// Reset (rst_n low, asynchronous) empties both polygons, clears the overflow
// flag and returns the sequencer to idle. Vertex memories are not cleared;
// only entries below the fill counts are ever used.
module convex_polygon_overlap_test #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         which_shape,
    input  logic signed [COORD_BITS-1:0] vertex_x,
    input  logic signed [COORD_BITS-1:0] vertex_y,
    input  logic                         last_of_pair,
    output logic                         done,
    output logic                         colliding,
    output logic                         degenerate,
    output logic                         overflowed
);
    import cpot_pkg::*;

    // Index width into a vertex memory, and fill count width (holds the depth).
    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    // Axis components are coordinate differences, one bit wider.
    localparam int AW = COORD_BITS + 1;
    // One product, and the sum of two products.
    localparam int MW = AW + COORD_BITS;
    localparam int PW = MW + 1;

    // Vertex memories, each entry holds {x, y}.
    logic [2*COORD_BITS-1:0] mem_a [MAX_VERTICES];
    logic [2*COORD_BITS-1:0] mem_b [MAX_VERTICES];
    logic [2*COORD_BITS-1:0] rd_a_reg;
    logic [2*COORD_BITS-1:0] rd_b_reg;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic          ovf_reg, ovf_next;
    logic          e_reg, e_next;        // polygon whose edges give the axes
    logic          s_reg, s_next;        // polygon being projected
    logic          rsel_reg, rsel_next;  // memory whose read data is used
    logic [IW-1:0] i_reg, i_next;        // edge index
    logic [IW-1:0] j_reg, j_next;        // projected vertex index
    logic          done_reg, done_next;
    logic          coll_reg, coll_next;
    logic          degen_reg, degen_next;
    logic          ovfo_reg, ovfo_next;

    // Datapath registers, no reset needed.
    logic signed [COORD_BITS-1:0] ex_reg, ex_next;
    logic signed [COORD_BITS-1:0] ey_reg, ey_next;
    logic signed [AW-1:0]         ax_reg, ax_next;
    logic signed [AW-1:0]         ay_reg, ay_next;
    logic signed [MW-1:0]         prod_reg, prod_next;
    logic signed [MW-1:0]         acc_reg, acc_next;
    logic signed [PW-1:0]         sum_reg, sum_next;
    logic signed [PW-1:0]         amin_reg, amin_next;
    logic signed [PW-1:0]         amax_reg, amax_next;
    logic signed [PW-1:0]         bmin_reg, bmin_next;
    logic signed [PW-1:0]         bmax_reg, bmax_next;

    logic                         accept;
    logic                         wr_a;
    logic                         wr_b;
    logic [IW-1:0]                rd_idx;
    logic [2*COORD_BITS-1:0]      rd_data;
    logic signed [COORD_BITS-1:0] rd_x;
    logic signed [COORD_BITS-1:0] rd_y;
    logic [CW-1:0]                cnt_e;
    logic [CW-1:0]                cnt_s;
    logic [IW-1:0]                last_i;
    logic [IW-1:0]                last_j;
    logic [IW-1:0]                k_idx;
    logic signed [AW-1:0]         mul_a;
    logic signed [COORD_BITS-1:0] mul_b;
    logic signed [MW-1:0]         mul_p;
    logic                         first_v;
    logic                         separated;

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign colliding  = coll_reg;
    assign degenerate = degen_reg;
    assign overflowed = ovfo_reg;

    // A beat is stored only if its polygon still has room.
    assign accept = start && !busy;
    assign wr_a   = accept && (which_shape == SHAPE_A) && (cnt_a_reg < CW'(MAX_VERTICES));
    assign wr_b   = accept && (which_shape == SHAPE_B) && (cnt_b_reg < CW'(MAX_VERTICES));

    // Edge endpoints and projection loop bounds. Counts are at least two here.
    assign cnt_e  = (e_reg == SHAPE_A) ? cnt_a_reg : cnt_b_reg;
    assign cnt_s  = (s_reg == SHAPE_A) ? cnt_a_reg : cnt_b_reg;
    assign last_i = IW'(cnt_e - CW'(1));
    assign last_j = IW'(cnt_s - CW'(1));
    assign k_idx  = (i_reg == last_i) ? '0 : i_reg + IW'(1);

    always_comb
    begin
        case (state_reg)
            ST_E0:    rd_idx = i_reg;
            ST_E1:    rd_idx = k_idx;
            default:  rd_idx = j_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[cnt_a_reg[IW-1:0]] <= {vertex_x, vertex_y};
        end
        rd_a_reg <= mem_a[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            mem_b[cnt_b_reg[IW-1:0]] <= {vertex_x, vertex_y};
        end
        rd_b_reg <= mem_b[rd_idx];
    end

    assign rd_data = (rsel_reg == SHAPE_A) ? rd_a_reg : rd_b_reg;
    assign rd_x    = rd_data[2*COORD_BITS-1:COORD_BITS];
    assign rd_y    = rd_data[COORD_BITS-1:0];

    // The one shared multiplier: axis x times vertex x, then axis y times vertex y.
    assign mul_a = (state_reg == ST_PMULX) ? ax_reg : ay_reg;
    assign mul_b = (state_reg == ST_PMULX) ? rd_x : rd_y;
    assign mul_p = MW'(mul_a) * MW'(mul_b);

    assign first_v   = (j_reg == '0);
    // Only a strict gap separates; touching intervals overlap.
    assign separated = (amin_reg > bmax_reg) || (amax_reg < bmin_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        ovf_next   = ovf_reg;
        e_next     = e_reg;
        s_next     = s_reg;
        rsel_next  = rsel_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        done_next  = 1'b0;
        coll_next  = coll_reg;
        degen_next = degen_reg;
        ovfo_next  = ovfo_reg;
        ex_next    = ex_reg;
        ey_next    = ey_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        sum_next   = sum_reg;
        amin_next  = amin_reg;
        amax_next  = amax_reg;
        bmin_next  = bmin_reg;
        bmax_next  = bmax_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (wr_a)
                    begin
                        cnt_a_next = cnt_a_reg + CW'(1);
                    end
                    else if (wr_b)
                    begin
                        cnt_b_next = cnt_b_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_of_pair)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if ((cnt_a_reg < CW'(MIN_POINTS)) || (cnt_b_reg < CW'(MIN_POINTS)))
                begin
                    done_next  = 1'b1;
                    coll_next  = 1'b0;
                    degen_next = 1'b1;
                    ovfo_next  = ovf_reg;
                    cnt_a_next = '0;
                    cnt_b_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    e_next     = SHAPE_A;
                    i_next     = '0;
                    state_next = ST_E0;
                end
            end
            ST_E0:
            begin
                rsel_next  = e_reg;
                state_next = ST_E1;
            end
            ST_E1:
            begin
                ex_next    = rd_x;
                ey_next    = rd_y;
                state_next = ST_E2;
            end
            ST_E2:
            begin
                // Normal of the edge from vertex i to vertex k: (dy, -dx).
                ax_next    = AW'(rd_y) - AW'(ey_reg);
                ay_next    = AW'(ex_reg) - AW'(rd_x);
                s_next     = SHAPE_A;
                j_next     = '0;
                state_next = ST_PADDR;
            end
            ST_PADDR:
            begin
                rsel_next  = s_reg;
                state_next = ST_PMULX;
            end
            ST_PMULX:
            begin
                prod_next  = mul_p;
                state_next = ST_PMULY;
            end
            ST_PMULY:
            begin
                acc_next   = prod_reg;
                prod_next  = mul_p;
                state_next = ST_PACC;
            end
            ST_PACC:
            begin
                sum_next   = PW'(acc_reg) + PW'(prod_reg);
                state_next = ST_PCMP;
            end
            ST_PCMP:
            begin
                if (s_reg == SHAPE_A)
                begin
                    if (first_v || (sum_reg < amin_reg))
                    begin
                        amin_next = sum_reg;
                    end
                    if (first_v || (sum_reg > amax_reg))
                    begin
                        amax_next = sum_reg;
                    end
                end
                else
                begin
                    if (first_v || (sum_reg < bmin_reg))
                    begin
                        bmin_next = sum_reg;
                    end
                    if (first_v || (sum_reg > bmax_reg))
                    begin
                        bmax_next = sum_reg;
                    end
                end
                if (j_reg == last_j)
                begin
                    if (s_reg == SHAPE_A)
                    begin
                        s_next     = SHAPE_B;
                        j_next     = '0;
                        state_next = ST_PADDR;
                    end
                    else
                    begin
                        state_next = ST_TEST;
                    end
                end
                else
                begin
                    j_next     = j_reg + IW'(1);
                    state_next = ST_PADDR;
                end
            end
            ST_TEST:
            begin
                if (separated || ((e_reg == SHAPE_B) && (i_reg == last_i)))
                begin
                    done_next  = 1'b1;
                    coll_next  = !separated;
                    degen_next = 1'b0;
                    ovfo_next  = ovf_reg;
                    cnt_a_next = '0;
                    cnt_b_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
                else if (i_reg == last_i)
                begin
                    e_next     = SHAPE_B;
                    i_next     = '0;
                    state_next = ST_E0;
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = ST_E0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            ovf_reg   <= 1'b0;
            e_reg     <= SHAPE_A;
            s_reg     <= SHAPE_A;
            rsel_reg  <= SHAPE_A;
            i_reg     <= '0;
            j_reg     <= '0;
            done_reg  <= 1'b0;
            coll_reg  <= 1'b0;
            degen_reg <= 1'b0;
            ovfo_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            ovf_reg   <= ovf_next;
            e_reg     <= e_next;
            s_reg     <= s_next;
            rsel_reg  <= rsel_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            done_reg  <= done_next;
            coll_reg  <= coll_next;
            degen_reg <= degen_next;
            ovfo_reg  <= ovfo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ex_reg   <= ex_next;
        ey_reg   <= ey_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        sum_reg  <= sum_next;
        amin_reg <= amin_next;
        amax_reg <= amax_next;
        bmin_reg <= bmin_next;
        bmax_reg <= bmax_next;
    end

endmodule

[sv/cpot_checker.sv]
// Port-level checker of the convex polygon overlap test and its bind statement.
module cpot_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_of_pair,
    input logic done,
    input logic colliding,
    input logic degenerate
);
    import cpot_pkg::*;

    // The test ends exactly when the result beat is shown.
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result beat");

    // A result beat lasts one cycle.
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat held for more than one cycle");

    // A vertex that does not close the pair is stored without raising busy.
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_of_pair) |=> !busy)
        else $error("plain vertex load left the block busy");

    // The closing vertex starts the test.
    a_last_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_of_pair) |=> busy)
        else $error("closing vertex did not start the test");

    // A degenerate pair never reports a collision.
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> !colliding)
        else $error("degenerate result reported a collision");

endmodule

bind convex_polygon_overlap_test cpot_checker u_cpot_checker (.*);
